@@ rtl/core/led_mode_breath_beep_controller_defines.svh @@
// Assertion macros used by the top RTL file of the LED mode controller.
`ifndef LED_MODE_BREATH_BEEP_CONTROLLER_DEFINES_SVH
`define LED_MODE_BREATH_BEEP_CONTROLLER_DEFINES_SVH

// Checked at every clock edge outside of reset.
`define LMBB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define LMBB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/lmbb_pkg.sv @@
package lmbb_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DutyW     = 16;
  localparam int unsigned StepW     = 10;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned RampW     = DutyW + 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  localparam logic [DutyW-1:0] GreenMaxRst     = 16'd999;
  localparam logic [StepW-1:0] RampStepRst     = 10'd10;
  localparam logic [DutyW-1:0] BeepIntervalRst = 16'd500;
  localparam logic [DutyW-1:0] BeepLevelRst    = 16'd100;

  typedef enum logic [ModeW-1:0] {
    MODE_GREEN  = 2'd0,
    MODE_RED    = 2'd1,
    MODE_BREATH = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic [CmdW-1:0] {
    CMD_DISPLAY = 2'd0,
    CMD_KEY1    = 2'd1,
    CMD_KEY2    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GREEN_MAX     = 2'd0,
    CFG_RAMP_STEP     = 2'd1,
    CFG_BEEP_INTERVAL = 2'd2,
    CFG_BEEP_LEVEL    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DutyW-1:0] green_max;
    logic [StepW-1:0] ramp_step;
    logic [DutyW-1:0] beep_interval;
    logic [DutyW-1:0] beep_level;
  } cfg_t;

  typedef struct packed {
    logic             red_on;
    logic [DutyW-1:0] green_duty;
    logic [DutyW-1:0] beep_duty;
    mode_e            mode;
  } result_t;

endpackage

@@ rtl/core/lmbb_cfg.sv @@
module lmbb_cfg
  import lmbb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GREEN_MAX:     cfg_d.green_max     = cfg_wdata_i;
        CFG_RAMP_STEP:     cfg_d.ramp_step     = cfg_wdata_i[StepW-1:0];
        CFG_BEEP_INTERVAL: cfg_d.beep_interval = cfg_wdata_i;
        CFG_BEEP_LEVEL:    cfg_d.beep_level    = cfg_wdata_i;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_max     <= GreenMaxRst;
      cfg_q.ramp_step     <= RampStepRst;
      cfg_q.beep_interval <= BeepIntervalRst;
      cfg_q.beep_level    <= BeepLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/lmbb_state.sv @@
module lmbb_state
  import lmbb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cmd_e             cmd_i,
  input  logic [TimeW-1:0] now_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  mode_e                   cur_mode_q, cur_mode_d;
  logic                    off_q, off_d;
  logic [DutyW-1:0]        level_q, level_d;
  logic                    down_q, down_d;
  logic                    beep_q, beep_d;
  logic [TimeW-1:0]        last_q, last_d;

  logic [TimeW-1:0]        elapsed;
  logic                    beep_now;
  logic signed [RampW-1:0] next_s;
  logic signed [RampW-1:0] top_s;
  mode_e                   mode_next;

  always_comb begin
    cur_mode_d = cur_mode_q;
    off_d      = off_q;
    level_d    = level_q;
    down_d     = down_q;
    beep_d     = beep_q;
    last_d     = last_q;
    mode_next  = cur_mode_q;

    elapsed  = now_i - last_q;
    beep_now = beep_q;
    top_s    = signed'({2'b00, cfg_i.green_max});
    if (down_q) begin
      next_s = signed'({2'b00, level_q}) - signed'({8'b0, cfg_i.ramp_step});
    end else begin
      next_s = signed'({2'b00, level_q}) + signed'({8'b0, cfg_i.ramp_step});
    end

    res_o.red_on     = 1'b0;
    res_o.green_duty = '0;
    res_o.beep_duty  = '0;
    res_o.mode       = off_q ? MODE_OFF : cur_mode_q;

    unique case (cmd_i)
      CMD_DISPLAY: begin
        if (off_q) begin
          res_o.mode = MODE_OFF;
        end else begin
          unique case (cur_mode_q)
            MODE_GREEN: begin
              res_o.green_duty = cfg_i.green_max;
              res_o.beep_duty  = cfg_i.beep_level;
            end
            MODE_RED: begin
              res_o.red_on = 1'b1;
            end
            MODE_BREATH: begin
              res_o.green_duty = (level_q > cfg_i.green_max) ? cfg_i.green_max : level_q;
              if (elapsed >= {16'b0, cfg_i.beep_interval}) begin
                last_d   = now_i;
                beep_now = ~beep_q;
              end
              beep_d          = beep_now;
              res_o.beep_duty = beep_now ? cfg_i.beep_level : '0;
              down_d          = down_q;
              if (next_s >= top_s) begin
                next_s = top_s;
                down_d = 1'b1;
              end
              if (next_s[RampW-1] || (next_s == '0)) begin
                next_s = '0;
                down_d = 1'b0;
              end
              level_d = next_s[DutyW-1:0];
            end
            default: begin
              res_o.green_duty = '0;
            end
          endcase
        end
      end
      CMD_KEY1: begin
        if (off_q) begin
          mode_next = MODE_GREEN;
        end else if (cur_mode_q == MODE_BREATH || cur_mode_q == MODE_OFF) begin
          mode_next = MODE_GREEN;
        end else begin
          mode_next = mode_e'(cur_mode_q + 2'd1);
        end
        off_d      = 1'b0;
        cur_mode_d = mode_next;
        if (mode_next == MODE_BREATH) begin
          level_d = '0;
          down_d  = 1'b0;
          beep_d  = 1'b0;
          last_d  = now_i;
        end
        res_o.mode = mode_next;
      end
      CMD_KEY2: begin
        off_d            = 1'b1;
        res_o.green_duty = cfg_i.green_max;
        res_o.mode       = MODE_OFF;
      end
      CMD_NONE: begin
        res_o.red_on = 1'b0;
      end
      default: begin
        res_o.red_on = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode_q <= MODE_GREEN;
      off_q      <= 1'b0;
      level_q    <= '0;
      down_q     <= 1'b0;
      beep_q     <= 1'b0;
      last_q     <= '0;
    end else if (step_i) begin
      cur_mode_q <= cur_mode_d;
      off_q      <= off_d;
      level_q    <= level_d;
      down_q     <= down_d;
      beep_q     <= beep_d;
      last_q     <= last_d;
    end
  end

endmodule

@@ rtl/core/led_mode_breath_beep_controller.sv @@
// LED mode controller: each input transaction carries a command (display step, key1,
// key2 or none) and a millisecond timestamp, and yields exactly one output transaction
// with the red pin, the green and buzzer PWM compares and the shown mode. A transaction
// goes through an input register, the combinational mode, ramp and beep logic, and an
// output register, from which its result is presented on the output. One transaction is
// taken every cycle while the output side keeps up; the mode and ramp registers are
// updated in the same cycle as the output register, which sets this rate. Configuration
// writes take effect on the next cycle and are meant to be made while no transaction is
// in flight.
`include "led_mode_breath_beep_controller_defines.svh"

module led_mode_breath_beep_controller
  import lmbb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] command, [33:2] now_ms, [39:34] unused
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] red_on, [16:1] green_duty, [32:17] beep_duty, [34:33] mode, [39:35] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t             cfg;
  result_t          res;
  result_t          res_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  cmd_e             in_cmd_q;
  logic [TimeW-1:0] in_now_q;
  logic             in_take;
  logic             adv;

  lmbb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lmbb_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .cmd_i  (in_cmd_q),
    .now_i  (in_now_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_q);
    out_valid_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= cmd_e'(s_axis_tdata[CmdW-1:0]);
      in_now_q <= s_axis_tdata[CmdW+TimeW-1:CmdW];
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.mode, res_q.beep_duty, res_q.green_duty, res_q.red_on};

  `LMBB_ASSERT(a_out_hold, (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)), "result changed while waiting")
  `LMBB_ASSERT(a_stall_cause, !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready), "input stalled without a full pipeline")
  `LMBB_ASSERT(a_red_mode, (out_valid_q && res_q.red_on) |-> (res_q.mode == MODE_RED), "red lit outside red mode")
  `LMBB_ASSERT(a_beep_mode, (out_valid_q && (res_q.beep_duty != '0)) |-> (res_q.mode == MODE_GREEN || res_q.mode == MODE_BREATH), "beep outside green or breathing")

endmodule
